// ===== hdl/pmf_pkg.sv =====
// Shared types, constants and median functions for the 5x5 pseudo-median filter.
// Used by pmf_lane, pseudo_median_5x5_filter and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package pmf_pkg;

    // Pixel channel and window shapes.
    localparam int CHANNEL_BITS = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int WIN_SIZE     = 5;
    localparam int WIN_ELEMS    = WIN_SIZE * WIN_SIZE;
    localparam int NINE         = 9;
    localparam int NINE_OFS_1   = 8;
    localparam int NINE_OFS_2   = 16;
    localparam int EDGE_MARGIN  = 2;
    localparam int FIRST_FILT   = 4;
    localparam int NUM_BANKS    = 4;
    localparam int BANK_BITS    = 2;

    // Frame size limits.
    localparam int CFG_BITS  = 11;
    localparam int ROW_BITS  = 10;
    localparam int ROW_LIMIT = 1024;
    localparam int OUT_BITS  = 10;

    // Result queue sizing.
    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int FIFO_CW     = 4;
    localparam int FIFO_LIMIT  = FIFO_DEPTH - 2 * MAX_RESULTS;

    typedef logic [CHANNEL_BITS-1:0]                   t_chan;
    typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] t_rgb;
    typedef logic [WIN_SIZE-1:0][CHANNEL_BITS-1:0]     t_col;
    typedef logic [WIN_ELEMS-1:0][CHANNEL_BITS-1:0]    t_win;
    typedef logic [NINE-1:0][CHANNEL_BITS-1:0]         t_nine;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    // One result item as held in the output queue.
    typedef struct packed {
        logic [OUT_BITS-1:0] row;
        logic [OUT_BITS-1:0] col;
        t_rgb                px;
        logic                last;
    } t_result;

    function automatic t_chan med3(input t_chan a, input t_chan b, input t_chan c);
        t_chan m;
        if (a < b) begin
            m = (b < c) ? b : ((c < a) ? a : c);
        end else begin
            m = (c < b) ? b : ((a < c) ? a : c);
        end
        return m;
    endfunction

    function automatic t_chan med9(input t_nine s);
        return med3(med3(s[0], s[3], s[6]), med3(s[7], s[1], s[4]),
                    med3(s[5], s[8], s[2]));
    endfunction

    function automatic t_chan med25(input t_win v);
        return med3(med9(v[8:0]), med9(v[16:8]), med9(v[24:16]));
    endfunction

endpackage

// ===== hdl/pmf_ram.sv =====
// Generic simple dual-port RAM with a registered, write-first read port.
// Used for the line-store banks; no dependencies.
`timescale 1ns / 1ps

module pmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address written in the same cycle returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pmf_lane.sv =====
// One channel lane: 5x5 window register and the median-of-medians network.
// Depends on pmf_pkg for types and the median functions.
`timescale 1ns / 1ps

module pmf_lane (
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic           i_filt,
    input  pmf_pkg::t_col  i_col,
    output pmf_pkg::t_chan o_med
);

    pmf_pkg::t_win  r_win;
    pmf_pkg::t_win  n_win;
    pmf_pkg::t_win  w_shift;
    pmf_pkg::t_chan w_med;

    // Shift the window left by one column and bring in the new column.
    always_comb begin
        for (int i = 0; i < pmf_pkg::WIN_SIZE; i++) begin
            for (int j = 0; j < pmf_pkg::WIN_SIZE; j++) begin
                if (j == pmf_pkg::WIN_SIZE - 1) begin
                    w_shift[i * pmf_pkg::WIN_SIZE + j] = i_col[i];
                end else begin
                    w_shift[i * pmf_pkg::WIN_SIZE + j] = r_win[i * pmf_pkg::WIN_SIZE + j + 1];
                end
            end
        end
    end

    // The filtered center is written back so later windows see it.
    always_comb begin
        w_med = pmf_pkg::med25(w_shift);
        n_win = w_shift;
        if (i_filt) begin
            n_win[pmf_pkg::WIN_ELEMS / 2] = w_med;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win <= n_win;
        end
    end

    assign o_med = w_med;

endmodule

// ===== hdl/pseudo_median_5x5_filter.sv =====
// Top level of the in-place 5x5 pseudo-median filter for raster RGB pixels.
// Depends on pmf_pkg, pmf_ram (four line-store banks) and pmf_lane (one per channel).
// An accepted pixel item is registered in stage 1, and its result items are then written
// into the output queue, which offers them on o_valid.
// Throughput: one pixel item per cycle; o_ready drops while more than four results wait.
// Reset (synchronous, active low) clears position, queue and sizes to 1024 x 1024.
`timescale 1ns / 1ps

module pseudo_median_5x5_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_out_row,
    output logic [9:0]  o_out_col,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > pmf_pkg::CFG_BITS) ? CW + 1 : pmf_pkg::CFG_BITS;
    localparam int HW = pmf_pkg::CFG_BITS;
    localparam int RW = pmf_pkg::ROW_BITS;
    localparam int PW = pmf_pkg::NUM_CHANNELS * pmf_pkg::CHANNEL_BITS;

    // Configuration registers.
    logic [HW-1:0] r_img_w;
    logic [HW-1:0] r_img_h;

    // Raster position.
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;

    // Stage 1 registers.
    logic                 r_s1_valid;
    logic                 r_s1_filt;
    logic                 r_s1_pass;
    logic [RW-1:0]        r_s1_row;
    logic [CW-1:0]        r_s1_col;
    pmf_pkg::t_rgb        r_s1_px;

    // Output queue.
    pmf_pkg::t_result            r_fifo [pmf_pkg::FIFO_DEPTH];
    logic [pmf_pkg::FIFO_AW-1:0] r_head;
    logic [pmf_pkg::FIFO_AW-1:0] r_tail;
    logic [pmf_pkg::FIFO_CW-1:0] r_cnt;

    logic          w_accept;
    logic          w_pop;
    logic [WW-1:0] w_w_eff;
    logic [WW-1:0] w_w_cfg;
    logic [HW-1:0] w_h_eff;
    logic [RW-1:0] w_r;
    logic [CW-1:0] w_c;
    logic [WW-1:0] w_c_ext;
    logic [HW-1:0] w_r_ext;
    logic          w_small;
    logic          w_filt;
    logic          w_pass;
    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    pmf_pkg::t_rgb w_px_in;

    logic [pmf_pkg::BANK_BITS-1:0] w_bank_px;
    logic [pmf_pkg::BANK_BITS-1:0] w_bank_res;
    logic [CW-1:0]                 w_col_res;
    logic [PW-1:0]                 w_rd [pmf_pkg::NUM_BANKS];
    pmf_pkg::t_rgb                 w_res;
    pmf_pkg::t_result              w_item_a;
    pmf_pkg::t_result              w_item_b;
    logic [1:0]                    w_push_n;

    assign o_cfg_ready = i_rst_n;
    assign w_accept    = i_valid && o_ready;
    assign o_ready     = i_rst_n && (r_cnt <= pmf_pkg::FIFO_CW'(pmf_pkg::FIFO_LIMIT));
    assign w_px_in     = {i_blue_in, i_green_in, i_red_in};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= HW'(1024);
            r_img_h <= HW'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pmf_pkg::CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                pmf_pkg::CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective frame size.
    always_comb begin
        w_w_cfg = WW'(r_img_w);
        if (r_img_w == '0) begin
            w_w_eff = WW'(1);
        end else if (w_w_cfg > WW'(MAX_WIDTH)) begin
            w_w_eff = WW'(MAX_WIDTH);
        end else begin
            w_w_eff = w_w_cfg;
        end
        if (r_img_h == '0) begin
            w_h_eff = HW'(1);
        end else if (r_img_h > HW'(pmf_pkg::ROW_LIMIT)) begin
            w_h_eff = HW'(pmf_pkg::ROW_LIMIT);
        end else begin
            w_h_eff = r_img_h;
        end
    end

    // Position of the incoming pixel, its result flags and the next position.
    always_comb begin
        w_r     = i_frame_start ? '0 : r_row;
        w_c     = i_frame_start ? '0 : r_col;
        w_c_ext = WW'(w_c);
        w_r_ext = HW'(w_r);
        w_small = (w_h_eff < HW'(pmf_pkg::WIN_SIZE)) || (w_w_eff < WW'(pmf_pkg::WIN_SIZE));
        w_filt  = !w_small && (w_r_ext >= HW'(pmf_pkg::FIRST_FILT))
                  && (w_c_ext >= WW'(pmf_pkg::FIRST_FILT))
                  && (w_r_ext < w_h_eff) && (w_c_ext < w_w_eff);
        w_pass  = w_small || (w_r_ext < HW'(pmf_pkg::EDGE_MARGIN))
                  || (w_c_ext < WW'(pmf_pkg::EDGE_MARGIN))
                  || (w_r_ext + HW'(pmf_pkg::EDGE_MARGIN) >= w_h_eff)
                  || (w_c_ext + WW'(pmf_pkg::EDGE_MARGIN) >= w_w_eff);
        if (w_c_ext + WW'(1) >= w_w_eff) begin
            n_col = '0;
            n_row = (w_r_ext + HW'(1) >= w_h_eff) ? '0 : w_r + RW'(1);
        end else begin
            n_col = w_c + CW'(1);
            n_row = w_r;
        end
    end

    // Position and stage 1 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // Stage 1 payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_filt <= w_filt;
            r_s1_pass <= w_pass;
            r_s1_row  <= w_r;
            r_s1_col  <= w_c;
            r_s1_px   <= w_px_in;
        end
    end

    // Line store: one bank per row modulo four.
    assign w_bank_px  = r_s1_row[pmf_pkg::BANK_BITS-1:0];
    assign w_bank_res = w_bank_px - pmf_pkg::BANK_BITS'(pmf_pkg::EDGE_MARGIN);
    assign w_col_res  = r_s1_col - CW'(pmf_pkg::EDGE_MARGIN);

    for (genvar b = 0; b < pmf_pkg::NUM_BANKS; b++) begin : g_bank
        logic          w_hit_px;
        logic          w_hit_res;
        logic          w_we;
        logic [CW-1:0] w_waddr;
        logic [PW-1:0] w_wdata;

        assign w_hit_px  = r_s1_valid && (w_bank_px == pmf_pkg::BANK_BITS'(b));
        assign w_hit_res = r_s1_valid && r_s1_filt
                           && (w_bank_res == pmf_pkg::BANK_BITS'(b));
        assign w_we      = w_hit_px || w_hit_res;
        assign w_waddr   = w_hit_px ? r_s1_col : w_col_res;
        assign w_wdata   = w_hit_px ? PW'(r_s1_px) : PW'(w_res);

        pmf_ram #(
            .WIDTH (PW),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_c),
            .o_rdata (w_rd[b])
        );
    end

    // Channel lanes; window row k comes from bank (row + k) modulo four.
    for (genvar ch = 0; ch < pmf_pkg::NUM_CHANNELS; ch++) begin : g_lane
        pmf_pkg::t_col w_col;

        always_comb begin
            for (int k = 0; k < pmf_pkg::NUM_BANKS; k++) begin
                w_col[k] = w_rd[w_bank_px + pmf_pkg::BANK_BITS'(k)]
                               [ch * pmf_pkg::CHANNEL_BITS +: pmf_pkg::CHANNEL_BITS];
            end
            w_col[pmf_pkg::WIN_SIZE-1] = r_s1_px[ch];
        end

        pmf_lane u_lane (
            .i_clk  (i_clk),
            .i_adv  (r_s1_valid),
            .i_filt (r_s1_filt),
            .i_col  (w_col),
            .o_med  (w_res[ch])
        );
    end

    // Merge the lane results into result items.
    always_comb begin
        w_item_a.row  = pmf_pkg::OUT_BITS'(r_s1_row - RW'(pmf_pkg::EDGE_MARGIN));
        w_item_a.col  = pmf_pkg::OUT_BITS'(w_col_res);
        w_item_a.px   = w_res;
        w_item_a.last = !r_s1_pass;
        w_item_b.row  = pmf_pkg::OUT_BITS'(r_s1_row);
        w_item_b.col  = pmf_pkg::OUT_BITS'(r_s1_col);
        w_item_b.px   = r_s1_px;
        w_item_b.last = 1'b1;
        w_push_n      = r_s1_valid ? (2'(r_s1_filt) + 2'(r_s1_pass)) : 2'd0;
    end

    // Output queue: up to two items pushed per cycle, one popped.
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_filt) begin
            r_fifo[r_tail] <= w_item_a;
            if (r_s1_pass) begin
                r_fifo[r_tail + pmf_pkg::FIFO_AW'(1)] <= w_item_b;
            end
        end else if (r_s1_valid && r_s1_pass) begin
            r_fifo[r_tail] <= w_item_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + pmf_pkg::FIFO_AW'(w_push_n);
            if (w_pop) begin
                r_head <= r_head + pmf_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + pmf_pkg::FIFO_CW'(w_push_n) - pmf_pkg::FIFO_CW'(w_pop);
        end
    end

    assign o_valid       = (r_cnt != '0);
    assign o_out_row     = r_fifo[r_head].row;
    assign o_out_col     = r_fifo[r_head].col;
    assign o_red_out     = r_fifo[r_head].px[0];
    assign o_green_out   = r_fifo[r_head].px[1];
    assign o_blue_out    = r_fifo[r_head].px[2];
    assign o_last_of_run = r_fifo[r_head].last;

    // The queue never holds more items than it has entries.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pmf_pkg::FIFO_CW'(pmf_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A filtered pixel always has a full window above and to the left.
    a_filt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_filt) |->
        (r_s1_row >= RW'(pmf_pkg::FIRST_FILT)) && (r_s1_col >= CW'(pmf_pkg::FIRST_FILT)))
        else $error("filtered pixel too close to the frame origin");

    // An accepted item reaches stage 1 in the next cycle.
    a_stage_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted item lost before stage 1");

    // The two line-store writes of one item never hit the same bank.
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_filt) |-> (w_bank_px != w_bank_res))
        else $error("line-store write collision");

endmodule

// ===== tb/pseudo_median_5x5_filter_tb.sv =====
// Self-checking testbench for the in-place 5x5 pseudo-median filter.
// Depends on pmf_pkg and pseudo_median_5x5_filter; it predicts every result itself.
`timescale 1ns / 1ps

module pseudo_median_5x5_filter_tb;

    localparam int LINE_W      = 1024;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_final_px;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_red_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_blue_in = '0;
    logic        i_frame_start = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_out_row;
    logic [9:0]  o_out_col;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic        o_last_of_run;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    pseudo_median_5x5_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: sizes, raster position, line store and windows.
    logic [10:0] width_reg = 11'd1024;
    logic [10:0] height_reg = 11'd1024;
    int          pos_row = 0;
    int          pos_col = 0;
    logic [7:0]  line_mem [3][4*LINE_W];
    logic [7:0]  win_px [3][5][5];
    t_final_px   final_px_due[$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    task automatic report(input string what, input logic [10:0] got, input logic [10:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [7:0] mid_of_three(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        if (a < b) return (b < c) ? b : ((c < a) ? a : c);
        return (c < b) ? b : ((a < c) ? a : c);
    endfunction

    // Median of three medians over the nine values starting at offset o.
    function automatic logic [7:0] nine_median(input logic [7:0] v [25], input int o);
        return mid_of_three(mid_of_three(v[o], v[o+3], v[o+6]),
                            mid_of_three(v[o+7], v[o+1], v[o+4]),
                            mid_of_three(v[o+5], v[o+8], v[o+2]));
    endfunction

    // Advance the in-place filter by one accepted pixel and queue its final pixels.
    task automatic filter_pixel(input logic [7:0] px [3], input logic fs);
        int        w, h, r, c;
        logic      tiny;
        logic [7:0] v [25];
        logic [7:0] res [3];
        t_final_px fp;
        int        first;
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_W) ? LINE_W : width_reg);
        h = (height_reg == 0) ? 1 :
            ((height_reg > pmf_pkg::ROW_LIMIT) ? pmf_pkg::ROW_LIMIT : height_reg);
        if (fs) begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col % LINE_W;
        tiny = (h < 5) || (w < 5);
        first = final_px_due.size();
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 4; j++)
                    win_px[ch][i][j] = win_px[ch][i][j+1];
            for (int k = 0; k < 4; k++)
                win_px[ch][k][4] = line_mem[ch][((r + k) & 3) * LINE_W + c];
            win_px[ch][4][4] = px[ch];
            line_mem[ch][(r & 3) * LINE_W + c] = px[ch];
        end
        // Interior pixel two rows up and two columns left becomes final.
        if (!tiny && r >= 4 && c >= 4 && r < h && c < w) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 25; i++)
                    v[i] = win_px[ch][i / 5][i % 5];
                res[ch] = mid_of_three(nine_median(v, 0),
                                       nine_median(v, pmf_pkg::NINE_OFS_1),
                                       nine_median(v, pmf_pkg::NINE_OFS_2));
                win_px[ch][2][2] = res[ch];
                line_mem[ch][((r - 2) & 3) * LINE_W + (c - 2)] = res[ch];
            end
            fp = '{row: 10'(r - 2), col: 10'(c - 2), red: res[0], green: res[1],
                   blue: res[2], last: 1'b0};
            final_px_due.push_back(fp);
        end
        // Border pixels and tiny frames pass through unchanged.
        if (tiny || r < 2 || c < 2 || r + 2 >= h || c + 2 >= w) begin
            fp = '{row: 10'(r), col: 10'(c), red: px[0], green: px[1], blue: px[2],
                   last: 1'b0};
            final_px_due.push_back(fp);
        end
        if (final_px_due.size() > first)
            final_px_due[final_px_due.size() - 1].last = 1'b1;
        if (pos_col + 1 >= w) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    // Send one pixel item, with random idle cycles ahead of it.
    task automatic send_pixel(input logic [7:0] rd, input logic [7:0] gr,
                              input logic [7:0] bl, input logic fs);
        logic [7:0] px [3];
        px = '{rd, gr, bl};
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_red_in      <= rd;
        i_green_in    <= gr;
        i_blue_in     <= bl;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_ready);
        filter_pixel(px, fs);
    endtask

    // Let the block go idle: every final pixel out, then a short settle time.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (final_px_due.size() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input pmf_pkg::t_cfg_idx idx, input logic [10:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == pmf_pkg::CFG_IMAGE_WIDTH) width_reg = data;
        else height_reg = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
        drain();
        write_reg(pmf_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(pmf_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    // Receiver stalls at random per the current phase.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted result against the oldest pending final pixel.
    always @(posedge i_clk) begin
        t_final_px fp;
        if (i_rst_n && o_valid && i_ready) begin
            if (final_px_due.size() == 0) begin
                report("unexpected result row", {1'b0, o_out_row}, 11'd0);
            end else begin
                fp = final_px_due.pop_front();
                if (o_out_row !== fp.row) report("out_row", o_out_row, fp.row);
                if (o_out_col !== fp.col) report("out_col", o_out_col, fp.col);
                if (o_red_out !== fp.red) report("red_out", o_red_out, fp.red);
                if (o_green_out !== fp.green) report("green_out", o_green_out, fp.green);
                if (o_blue_out !== fp.blue) report("blue_out", o_blue_out, fp.blue);
                if (o_last_of_run !== fp.last)
                    report("last_of_run", o_last_of_run, fp.last);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pseudo_median_5x5_filter verification failed");
            $finish;
        end
    end

    // Tiny frame with width register 0: every pixel passes through.
    task automatic test_tiny_frame;
        set_frame(11'd0, 11'd3);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd128, 8'd1, 8'd127, 1'b0);
    endtask

    // Smallest frame that filters, with extreme channel values.
    task automatic test_min_frame;
        set_frame(11'd5, 11'd5);
        for (int i = 0; i < 25; i++)
            send_pixel($urandom_range(1) ? 8'd255 : 8'd0, $urandom_range(1) ? 8'd255 : 8'd0,
                       $urandom_range(1) ? 8'd255 : 8'd0, i == 0);
    endtask

    // Width register at its top value; the first row passes through unwrapped.
    task automatic test_wide_rows;
        set_frame(11'd2047, 11'd5);
        for (int i = 0; i < 40; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
    endtask

    // Height register at 0 and at its top value, then 1024 x 1024; only the first rows sent.
    task automatic test_tall_frames;
        set_frame(11'd5, 11'd0);
        for (int i = 0; i < 12; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
        set_frame(11'd5, 11'd2047);
        for (int i = 0; i < 40; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
        set_frame(11'd1024, 11'd1024);
        for (int i = 0; i < 8; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
    endtask

    // Random frames of mostly small sizes, with stray frame starts as noise.
    task automatic test_random_frames(input int idle_pct, input int stall_pct, input int n);
        int w, h, chunk;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (n > 0) begin
            w = ($urandom_range(9) < 8) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            h = ($urandom_range(9) < 8) ? $urandom_range(5, 9) : $urandom_range(1, 4);
            set_frame(11'(w), 11'(h));
            chunk = w * h * $urandom_range(1, 2);
            if (chunk > n) chunk = n;
            for (int i = 0; i < chunk; i++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                           i == 0 || (pos_row == 0 && pos_col == 0) ||
                           $urandom_range(99) < 2);
            n -= chunk;
        end
        drain();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_tiny_frame();
        test_min_frame();
        test_wide_rows();
        test_tall_frames();
        test_random_frames(0, 0, 260);
        test_random_frames(87, 0, 250);
        test_random_frames(0, 87, 250);
        test_random_frames(19, 19, 260);
        drain();
        if (error_count == 0) begin
            $display("pseudo_median_5x5_filter verification clean");
        end else begin
            $display("pseudo_median_5x5_filter verification failed");
        end
        $finish;
    end

endmodule
